/* rtl/trfw_pkg.sv */
package trfw_pkg;

    localparam logic [2:0] OP_FORWARD_READ = 3'd0;
    localparam logic [2:0] OP_ARCH_READ    = 3'd1;
    localparam logic [2:0] OP_EXECUTE      = 3'd2;
    localparam logic [2:0] OP_LOAD_DONE    = 3'd3;
    localparam logic [2:0] OP_CLOCK        = 3'd4;

    localparam logic [3:0]  PC_INDEX    = 4'd15;
    localparam logic [31:0] PC_LOAD_ADJ = 32'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  reg_index;
        logic        dest_valid;
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic        carry_in;
        logic        set_flags;
        logic        pause;
        logic        direct_write;
    } in_t;

    typedef struct packed {
        logic [31:0] data;
        logic        load_use_hazard;
        logic [3:0]  flags_pending;
        logic [3:0]  flags_committed;
        logic [31:0] execute_instruction;
        logic        exec_stage_valid;
    } out_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  idx;
        logic [31:0] value;
    } rf_wr_t;

    typedef struct packed {
        logic [31:0] sum;
        logic [3:0]  nzcv;
    } alu_res_t;

endpackage

/* rtl/trfw_alu.sv */
module trfw_alu (
    input  logic [31:0]        a,
    input  logic [31:0]        b,
    input  logic               cin,
    output trfw_pkg::alu_res_t res
);
    import trfw_pkg::*;

    logic [31:0] low;
    logic [32:0] full;
    logic        c31;
    logic        cout;

    assign low  = {1'b0, a[30:0]} + {1'b0, b[30:0]} + {31'd0, cin};
    assign full = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    assign c31  = low[31];
    assign cout = full[32];

    assign res.sum  = full[31:0];
    assign res.nzcv = {full[31], (full[31:0] == 32'd0), cout, c31 ^ cout};

endmodule

/* rtl/trfw_regfile.sv */
module trfw_regfile (
    input  logic                aclk,
    input  logic                aresetn,
    input  trfw_pkg::rf_wr_t    wr,
    input  logic [3:0]          rd_idx,
    output logic [31:0]         rd_data
);
    import trfw_pkg::*;

    logic [31:0] regs_reg [16];
    logic [31:0] wr_value;

    // The program counter is always held halfword aligned.
    assign wr_value = (wr.idx == PC_INDEX) ? {wr.value[31:1], 1'b0} : wr.value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                regs_reg[i] <= 32'd0;
            end
        end else if (wr.en) begin
            regs_reg[wr.idx] <= wr_value;
        end
    end

    assign rd_data = (rd_idx == PC_INDEX) ? {regs_reg[rd_idx][31:1], 1'b0}
                                          : regs_reg[rd_idx];

endmodule

/* rtl/thumb_regfile_forward_writeback.sv */
// Register file, writeback and operand forwarding of a small three-stage core.
// One request is taken per clock while s_ready is high, and its result appears
// on the m_ channel in the following cycle, held in an output register; s_ready
// stays high while that register is empty or being emptied, so sustained rate is
// one request per cycle as long as m_ready stays high.
module thumb_regfile_forward_writeback (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  trfw_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output trfw_pkg::out_t m_payload
);
    import trfw_pkg::*;

    logic        exec_dest_valid_reg, exec_dest_valid_next;
    logic [3:0]  exec_dest_reg, exec_dest_next;
    logic [31:0] alu_result_reg, alu_result_next;
    logic        load_pending_reg, load_pending_next;
    logic        load_target_valid_reg, load_target_valid_next;
    logic [3:0]  load_target_reg, load_target_next;
    logic [31:0] load_data_reg, load_data_next;
    logic [3:0]  nzcv_pending_reg, nzcv_pending_next;
    logic [3:0]  nzcv_reg, nzcv_next;
    logic [31:0] decode_instr_reg, decode_instr_next;
    logic        decode_valid_reg, decode_valid_next;
    logic [31:0] exec_instr_reg, exec_instr_next;
    logic        exec_valid_reg, exec_valid_next;
    logic        fetch_valid_reg, fetch_valid_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_payload_reg, m_payload_next;

    logic        accept;
    logic [31:0] rd_data;
    alu_res_t    alu_res;
    rf_wr_t      rf_wr;
    logic        hits_load;
    logic        hits_exec;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    trfw_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (rf_wr),
        .rd_idx  (s_payload.reg_index),
        .rd_data (rd_data)
    );

    trfw_alu u_alu (
        .a   (s_payload.value_a),
        .b   (s_payload.value_b),
        .cin (s_payload.carry_in),
        .res (alu_res)
    );

    assign hits_load = load_target_valid_reg && (s_payload.reg_index == load_target_reg);
    assign hits_exec = exec_dest_valid_reg && (s_payload.reg_index == exec_dest_reg);

    always_comb begin
        exec_dest_valid_next   = exec_dest_valid_reg;
        exec_dest_next         = exec_dest_reg;
        alu_result_next        = alu_result_reg;
        load_pending_next      = load_pending_reg;
        load_target_valid_next = load_target_valid_reg;
        load_target_next       = load_target_reg;
        load_data_next         = load_data_reg;
        nzcv_pending_next      = nzcv_pending_reg;
        nzcv_next              = nzcv_reg;
        decode_instr_next      = decode_instr_reg;
        decode_valid_next      = decode_valid_reg;
        exec_instr_next        = exec_instr_reg;
        exec_valid_next        = exec_valid_reg;
        fetch_valid_next       = fetch_valid_reg;
        rf_wr                  = '0;
        m_payload_next         = '0;

        case (s_payload.operation)
            OP_FORWARD_READ: begin
                m_payload_next.load_use_hazard = hits_load;
                if (hits_load) begin
                    m_payload_next.data = load_data_reg;
                end else if (hits_exec) begin
                    m_payload_next.data = alu_result_reg;
                end else begin
                    m_payload_next.data = rd_data;
                end
            end
            OP_ARCH_READ: begin
                m_payload_next.load_use_hazard = hits_load;
                m_payload_next.data            = rd_data;
            end
            OP_EXECUTE: begin
                m_payload_next.data = alu_res.sum;
                alu_result_next     = alu_res.sum;
                if (s_payload.set_flags) begin
                    nzcv_pending_next = alu_res.nzcv;
                end
            end
            OP_LOAD_DONE: begin
                if (s_payload.direct_write) begin
                    rf_wr.en    = accept;
                    rf_wr.idx   = s_payload.reg_index;
                    rf_wr.value = s_payload.value_a;
                end else begin
                    load_pending_next      = 1'b1;
                    load_target_valid_next = 1'b1;
                    load_target_next       = s_payload.reg_index;
                    load_data_next         = s_payload.value_a;
                end
            end
            OP_CLOCK: begin
                if (load_pending_reg) begin
                    rf_wr.en    = accept;
                    rf_wr.idx   = load_target_reg;
                    rf_wr.value = (load_target_reg == PC_INDEX)
                                  ? load_data_reg + PC_LOAD_ADJ : load_data_reg;
                    load_pending_next      = 1'b0;
                    load_target_valid_next = 1'b0;
                end else if (exec_dest_valid_reg) begin
                    rf_wr.en    = accept;
                    rf_wr.idx   = exec_dest_reg;
                    rf_wr.value = alu_result_reg;
                end
                if (s_payload.set_flags) begin
                    nzcv_next = nzcv_pending_reg;
                end
                exec_dest_next       = s_payload.reg_index;
                exec_dest_valid_next = s_payload.dest_valid;
                if (!s_payload.pause) begin
                    exec_instr_next   = decode_instr_reg;
                    exec_valid_next   = decode_valid_reg;
                    decode_instr_next = s_payload.value_a;
                    decode_valid_next = fetch_valid_reg;
                    fetch_valid_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        m_payload_next.flags_pending       = nzcv_pending_next;
        m_payload_next.flags_committed     = nzcv_next;
        m_payload_next.execute_instruction = exec_instr_next;
        m_payload_next.exec_stage_valid    = exec_valid_next;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exec_dest_valid_reg   <= 1'b0;
            exec_dest_reg         <= 4'd0;
            alu_result_reg        <= 32'd0;
            load_pending_reg      <= 1'b0;
            load_target_valid_reg <= 1'b0;
            load_target_reg       <= 4'd0;
            load_data_reg         <= 32'd0;
            nzcv_pending_reg      <= 4'd0;
            nzcv_reg              <= 4'd0;
            decode_instr_reg      <= 32'd0;
            decode_valid_reg      <= 1'b0;
            exec_instr_reg        <= 32'd0;
            exec_valid_reg        <= 1'b0;
            fetch_valid_reg       <= 1'b0;
            m_valid_reg           <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                exec_dest_valid_reg   <= exec_dest_valid_next;
                exec_dest_reg         <= exec_dest_next;
                alu_result_reg        <= alu_result_next;
                load_pending_reg      <= load_pending_next;
                load_target_valid_reg <= load_target_valid_next;
                load_target_reg       <= load_target_next;
                load_data_reg         <= load_data_next;
                nzcv_pending_reg      <= nzcv_pending_next;
                nzcv_reg              <= nzcv_next;
                decode_instr_reg      <= decode_instr_next;
                decode_valid_reg      <= decode_valid_next;
                exec_instr_reg        <= exec_instr_next;
                exec_valid_reg        <= exec_valid_next;
                fetch_valid_reg       <= fetch_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

/* rtl/trfw_checker.sv */
module trfw_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input trfw_pkg::in_t  s_payload,
    input logic           m_valid,
    input logic           m_ready,
    input trfw_pkg::out_t m_payload
);
    import trfw_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid directly after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed or vanished");

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("request refused while the result path was free");

    a_no_data_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        (s_payload.operation == OP_LOAD_DONE || s_payload.operation == OP_CLOCK)
        |=> m_valid && m_payload.data == 32'd0 && !m_payload.load_use_hazard)
        else $error("state update request returned data or a hazard");

endmodule

bind thumb_regfile_forward_writeback trfw_checker u_trfw_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

/* test/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import trfw_pkg::*;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID   = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [3:0] FLAG_N = 4'b1000;
    localparam logic [3:0] FLAG_Z = 4'b0100;
    localparam logic [3:0] FLAG_C = 4'b0010;
    localparam logic [3:0] FLAG_V = 4'b0001;

    localparam int RANDOM_REQUESTS = 1850;
    localparam int MAX_IDLE        = 18;
    localparam int DRAIN_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct {
        in_t  req;
        bit   fixed;
        out_t rsp;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_payload;
    logic m_valid;
    logic m_ready;
    out_t m_payload;

    // Shadow copy of the core state.
    logic [31:0] regs [16];
    logic        ex_dest_ok;
    logic [3:0]  ex_dest;
    logic [31:0] alu_sum;
    logic        ld_pending;
    logic        ld_target_ok;
    logic [3:0]  ld_target;
    logic [31:0] ld_word;
    logic [3:0]  nzcv_next;
    logic [3:0]  nzcv_now;
    logic [31:0] dec_instr;
    logic        dec_ok;
    logic [31:0] ex_instr;
    logic        ex_ok;
    logic        fetch_ok;

    out_t      awaited_results [$];
    stim_row_t directed_rows [$];
    int        failures = 0;
    int        cycle_count = 0;
    bit        no_idle = 1'b0;

    thumb_regfile_forward_writeback dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("thumb_regfile_forward_writeback test failed");
            $finish;
        end
    end

    function automatic logic [31:0] arch_word(input logic [3:0] idx);
        logic [31:0] word;
        word = regs[idx];
        if (idx == PC_INDEX) begin
            word[0] = 1'b0;
        end
        return word;
    endfunction

    function automatic void write_reg(input logic [3:0] idx, input logic [31:0] value);
        logic [31:0] word;
        word = value;
        if (idx == PC_INDEX) begin
            word[0] = 1'b0;
        end
        regs[idx] = word;
    endfunction

    function automatic out_t core_event(input in_t req);
        out_t        rsp;
        logic [32:0] wide;
        logic [31:0] a;
        logic [31:0] b;
        rsp = '0;
        a = req.value_a;
        b = req.value_b;
        case (req.operation)
            OP_FORWARD_READ: begin
                rsp.load_use_hazard = ld_target_ok && req.reg_index == ld_target;
                if (rsp.load_use_hazard) begin
                    rsp.data = ld_word;
                end else if (ex_dest_ok && req.reg_index == ex_dest) begin
                    rsp.data = alu_sum;
                end else begin
                    rsp.data = arch_word(req.reg_index);
                end
            end
            OP_ARCH_READ: begin
                rsp.load_use_hazard = ld_target_ok && req.reg_index == ld_target;
                rsp.data = arch_word(req.reg_index);
            end
            OP_EXECUTE: begin
                wide = {1'b0, a} + {1'b0, b} + {32'd0, req.carry_in};
                rsp.data = wide[31:0];
                alu_sum = wide[31:0];
                if (req.set_flags) begin
                    nzcv_next = {wide[31], wide[31:0] == 32'd0, wide[32],
                                 a[31] == b[31] && wide[31] != a[31]};
                end
            end
            OP_LOAD_DONE: begin
                if (req.direct_write) begin
                    write_reg(req.reg_index, a);
                end else begin
                    ld_pending = 1'b1;
                    ld_target_ok = 1'b1;
                    ld_target = req.reg_index;
                    ld_word = a;
                end
            end
            OP_CLOCK: begin
                if (ld_pending) begin
                    write_reg(ld_target,
                              ld_target == PC_INDEX ? ld_word + PC_LOAD_ADJ : ld_word);
                    ld_pending = 1'b0;
                    ld_target_ok = 1'b0;
                end else if (ex_dest_ok) begin
                    write_reg(ex_dest, alu_sum);
                end
                if (req.set_flags) begin
                    nzcv_now = nzcv_next;
                end
                ex_dest = req.reg_index;
                ex_dest_ok = req.dest_valid;
                if (!req.pause) begin
                    ex_instr = dec_instr;
                    ex_ok = dec_ok;
                    dec_instr = a;
                    dec_ok = fetch_ok;
                    fetch_ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        rsp.flags_pending = nzcv_next;
        rsp.flags_committed = nzcv_now;
        rsp.execute_instruction = ex_instr;
        rsp.exec_stage_valid = ex_ok;
        return rsp;
    endfunction

    function automatic in_t req_of(input logic [2:0] op, input logic [3:0] idx,
                                   input logic [31:0] a, input logic [31:0] b,
                                   input logic dv, input logic cin, input logic sf,
                                   input logic hold, input logic direct);
        in_t req;
        req.operation = op;
        req.reg_index = idx;
        req.dest_valid = dv;
        req.value_a = a;
        req.value_b = b;
        req.carry_in = cin;
        req.set_flags = sf;
        req.pause = hold;
        req.direct_write = direct;
        return req;
    endfunction

    function automatic out_t rsp_of(input logic [31:0] data, input logic hazard,
                                    input logic [3:0] pending, input logic [3:0] committed);
        out_t rsp;
        rsp.data = data;
        rsp.load_use_hazard = hazard;
        rsp.flags_pending = pending;
        rsp.flags_committed = committed;
        rsp.execute_instruction = 32'd0;
        rsp.exec_stage_valid = 1'b0;
        return rsp;
    endfunction

    function automatic void add_row(input in_t req, input bit fixed = 1'b0,
                                    input out_t rsp = '0);
        stim_row_t row;
        row.req = req;
        row.fixed = fixed;
        row.rsp = rsp;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_t random_request();
        in_t req;
        int  pick;
        req.value_a = random_word();
        req.value_b = random_word();
        req.carry_in = $urandom_range(0, 1) == 1;
        req.set_flags = $urandom_range(0, 1) == 1;
        req.pause = $urandom_range(0, 4) == 0;
        req.dest_valid = $urandom_range(0, 3) != 0;
        req.direct_write = $urandom_range(0, 3) == 0;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            req.operation = OP_FORWARD_READ;
        end else if (pick < 30) begin
            req.operation = OP_ARCH_READ;
        end else if (pick < 50) begin
            req.operation = OP_EXECUTE;
        end else if (pick < 65) begin
            req.operation = OP_LOAD_DONE;
        end else if (pick < 96) begin
            req.operation = OP_CLOCK;
        end else begin
            req.operation = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        case ($urandom_range(0, 5))
            0, 1: req.reg_index = ld_target;
            2: req.reg_index = ex_dest;
            3: req.reg_index = PC_INDEX;
            default: req.reg_index = 4'($urandom_range(0, 15));
        endcase
        return req;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic send_request(input in_t req, input bit fixed, input out_t literal);
        int   gap;
        out_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = core_event(req);
        awaited_results.push_back(fixed ? literal : predicted);
    endtask

    task automatic check_result(input out_t got);
        out_t want;
        if (awaited_results.size() == 0) begin
            note_failure("result arrived with no request outstanding");
        end else begin
            want = awaited_results.pop_front();
            if (got.data !== want.data)
                note_failure($sformatf("data: expected %h, got %h", want.data, got.data));
            if (got.load_use_hazard !== want.load_use_hazard)
                note_failure($sformatf("load_use_hazard: expected %b, got %b",
                                       want.load_use_hazard, got.load_use_hazard));
            if (got.flags_pending !== want.flags_pending)
                note_failure($sformatf("flags_pending: expected %h, got %h",
                                       want.flags_pending, got.flags_pending));
            if (got.flags_committed !== want.flags_committed)
                note_failure($sformatf("flags_committed: expected %h, got %h",
                                       want.flags_committed, got.flags_committed));
            if (got.execute_instruction !== want.execute_instruction)
                note_failure($sformatf("execute_instruction: expected %h, got %h",
                                       want.execute_instruction, got.execute_instruction));
            if (got.exec_stage_valid !== want.exec_stage_valid)
                note_failure($sformatf("exec_stage_valid: expected %b, got %b",
                                       want.exec_stage_valid, got.exec_stage_valid));
        end
    endtask

    initial begin : result_side
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_result(m_payload);
        end
    end

    initial begin : request_side
        in_t req;
        int  counted;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        foreach (regs[i]) begin
            regs[i] = 32'd0;
        end
        ex_dest_ok = 1'b0;
        ex_dest = 4'd0;
        alu_sum = 32'd0;
        ld_pending = 1'b0;
        ld_target_ok = 1'b0;
        ld_target = 4'd0;
        ld_word = 32'd0;
        nzcv_next = 4'd0;
        nzcv_now = 4'd0;
        dec_instr = 32'd0;
        dec_ok = 1'b0;
        ex_instr = 32'd0;
        ex_ok = 1'b0;
        fetch_ok = 1'b0;

        add_row(req_of(OP_FORWARD_READ, 4'd0, 32'd0, 32'd0, 0, 0, 0, 0, 0),
                1, rsp_of(32'd0, 0, 4'd0, 4'd0));
        add_row(req_of(OP_ARCH_READ, PC_INDEX, 32'd0, 32'd0, 0, 0, 0, 0, 0),
                1, rsp_of(32'd0, 0, 4'd0, 4'd0));
        add_row(req_of(OP_EXECUTE, 4'd0, 32'hFFFF_FFFF, 32'd0, 0, 1, 1, 0, 0),
                1, rsp_of(32'd0, 0, FLAG_Z | FLAG_C, 4'd0));
        add_row(req_of(OP_EXECUTE, 4'd0, 32'h7FFF_FFFF, 32'd1, 0, 0, 1, 0, 0),
                1, rsp_of(32'h8000_0000, 0, FLAG_N | FLAG_V, 4'd0));
        add_row(req_of(OP_EXECUTE, 4'd0, 32'h8000_0000, 32'h8000_0000, 0, 0, 1, 0, 0),
                1, rsp_of(32'd0, 0, FLAG_Z | FLAG_C | FLAG_V, 4'd0));
        add_row(req_of(OP_EXECUTE, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 0, 0, 0),
                1, rsp_of(32'hFFFF_FFFF, 0, FLAG_Z | FLAG_C | FLAG_V, 4'd0));
        add_row(req_of(OP_CLOCK, 4'd3, 32'hA0A0_A0A0, 32'd0, 1, 0, 1, 0, 0),
                1, rsp_of(32'd0, 0, FLAG_Z | FLAG_C | FLAG_V, FLAG_Z | FLAG_C | FLAG_V));
        add_row(req_of(OP_FORWARD_READ, 4'd3, 32'd0, 32'd0, 0, 0, 0, 0, 0),
                1, rsp_of(32'hFFFF_FFFF, 0, FLAG_Z | FLAG_C | FLAG_V,
                          FLAG_Z | FLAG_C | FLAG_V));
        add_row(req_of(OP_ARCH_READ, 4'd3, 32'd0, 32'd0, 0, 0, 0, 0, 0),
                1, rsp_of(32'd0, 0, FLAG_Z | FLAG_C | FLAG_V, FLAG_Z | FLAG_C | FLAG_V));
        add_row(req_of(OP_LOAD_DONE, PC_INDEX, 32'hFFFF_FFFF, 32'd0, 0, 0, 0, 0, 0),
                1, rsp_of(32'd0, 0, FLAG_Z | FLAG_C | FLAG_V, FLAG_Z | FLAG_C | FLAG_V));
        add_row(req_of(OP_FORWARD_READ, PC_INDEX, 32'd0, 32'd0, 0, 0, 0, 0, 0),
                1, rsp_of(32'hFFFF_FFFF, 1, FLAG_Z | FLAG_C | FLAG_V,
                          FLAG_Z | FLAG_C | FLAG_V));
        add_row(req_of(OP_ARCH_READ, PC_INDEX, 32'd0, 32'd0, 0, 0, 0, 0, 0),
                1, rsp_of(32'd0, 1, FLAG_Z | FLAG_C | FLAG_V, FLAG_Z | FLAG_C | FLAG_V));
        add_row(req_of(OP_LOAD_DONE, 4'd3, 32'd0, 32'd0, 0, 0, 0, 0, 0));
        add_row(req_of(OP_FORWARD_READ, 4'd3, 32'd0, 32'd0, 0, 0, 0, 0, 0),
                1, rsp_of(32'd0, 1, FLAG_Z | FLAG_C | FLAG_V, FLAG_Z | FLAG_C | FLAG_V));
        add_row(req_of(OP_LOAD_DONE, PC_INDEX, 32'hFFFF_FFFE, 32'd0, 0, 0, 0, 0, 0));
        add_row(req_of(OP_CLOCK, PC_INDEX, 32'h5555_5555, 32'd0, 1, 0, 0, 1, 0));
        add_row(req_of(OP_ARCH_READ, PC_INDEX, 32'd0, 32'd0, 0, 0, 0, 0, 0));
        add_row(req_of(OP_CLOCK, 4'd0, 32'h1234_5678, 32'd0, 0, 0, 1, 0, 0));
        add_row(req_of(OP_FORWARD_READ, PC_INDEX, 32'd0, 32'd0, 0, 0, 0, 0, 0));
        add_row(req_of(OP_LOAD_DONE, PC_INDEX, 32'hFFFF_FFFF, 32'd0, 0, 0, 0, 0, 1));
        add_row(req_of(OP_ARCH_READ, PC_INDEX, 32'd0, 32'd0, 0, 0, 0, 0, 0));
        add_row(req_of(OP_LOAD_DONE, 4'd0, 32'hFFFF_FFFF, 32'd0, 0, 0, 0, 0, 1));
        add_row(req_of(OP_SPARE_FIRST, PC_INDEX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 1, 1));
        add_row(req_of(OP_SPARE_MID, 4'd0, 32'd0, 32'd0, 0, 0, 0, 0, 0));
        add_row(req_of(OP_SPARE_LAST, PC_INDEX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 1, 1));
        add_row(req_of(OP_CLOCK, PC_INDEX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 0, 1));

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);
        end

        counted = 0;
        while (counted < RANDOM_REQUESTS) begin
            if (counted % 150 == 0) begin
                no_idle = $urandom_range(0, 2) == 0;
            end
            req = random_request();
            counted++;
            send_request(req, 1'b0, '0);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0 && awaited_results.size() == 0) begin
            $display("thumb_regfile_forward_writeback test passed");
        end else begin
            $display("thumb_regfile_forward_writeback test failed");
        end
        $finish;
    end
endmodule
